[hw/rtl/obb_sat_pkg.sv]
// Package: shared widths and constants for the OBB separating-axis unit.
package obb_sat_pkg;
  localparam int unsigned CoordBitsDefault = 24;
  localparam int unsigned AngleBitsDefault = 16;
  localparam int unsigned HalfBits         = 20;
  localparam int unsigned PenBits          = 23;
  localparam int unsigned NumAxes          = 4;
endpackage

[hw/rtl/obb_sat_collision_unit.sv]
// Top level: pipelined 2D oriented-box separating-axis collision test.
//
// Usage:
//   One item on the input channel carries two oriented boxes A and B
//   (center Q16.8, half extents Q12.8, axis as cos/sin Q2.14). One result
//   item leaves on the output channel for every input item: hit flag, unit
//   normal pointing away from B (Q2.14) and the smallest axis overlap as a
//   saturating Q15.8 penetration depth. A miss gives zeros.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low.
//   An accepted item passes through the register stages below before output
//   valid rises. Throughput: one item per cycle while the output is not stalled.
//   The four axes are worked in parallel lanes through five register stages
//   (axis dot products, radii products, interval bounds, overlaps, minimum
//   select / normal), so the pipeline depth, not any loop, sets the
//   latency.
//   Stall: an output stall freezes valid stages with no bubble after; empty
//   stages still fill, so a bubble is squeezed out before input is stalled.
//   Reset: clears all stage valid bits; payload registers are not reset.
module obb_sat_collision_unit
  import obb_sat_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDefault,
  parameter int unsigned ANGLE_BITS = AngleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_center_x_i,
  input  logic signed [COORD_BITS-1:0] a_center_y_i,
  input  logic        [HalfBits-1:0]   a_half_width_i,
  input  logic        [HalfBits-1:0]   a_half_height_i,
  input  logic signed [ANGLE_BITS-1:0] a_cos_i,
  input  logic signed [ANGLE_BITS-1:0] a_sin_i,
  input  logic signed [COORD_BITS-1:0] b_center_x_i,
  input  logic signed [COORD_BITS-1:0] b_center_y_i,
  input  logic        [HalfBits-1:0]   b_half_width_i,
  input  logic        [HalfBits-1:0]   b_half_height_i,
  input  logic signed [ANGLE_BITS-1:0] b_cos_i,
  input  logic signed [ANGLE_BITS-1:0] b_sin_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic signed [ANGLE_BITS-1:0] normal_x_o,
  output logic signed [ANGLE_BITS-1:0] normal_y_o,
  output logic        [PenBits-1:0]    penetration_o
);
  localparam int unsigned AF  = ANGLE_BITS - 2;
  localparam int unsigned AW  = ANGLE_BITS + 1;         // negated axis component
  localparam int unsigned DW  = 2 * AW + 1;             // exact dot product
  localparam int unsigned RDW = DW - AF + 1;            // rounded |dot|
  localparam int unsigned PW  = HalfBits + RDW + 2;     // radius (two terms)
  localparam int unsigned CW  = COORD_BITS + AW + 2;    // center projection
  localparam int unsigned BW  = (PW > CW ? PW : CW) + 2;// interval bound
  localparam int unsigned DDW = COORD_BITS + 1 + AW + 1;// (cB-cA).L
  localparam int unsigned NW  = ANGLE_BITS;

  // Stage enables: a stage advances when it is empty or the one after moves.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Candidate axes: A.x, A.y, B.x, B.y.
  logic signed [AW-1:0] axx [NumAxes];
  logic signed [AW-1:0] axy [NumAxes];
  always_comb begin
    axx[0] = AW'(a_cos_i);  axy[0] = AW'(a_sin_i);
    axx[1] = -AW'(a_sin_i); axy[1] = AW'(a_cos_i);
    axx[2] = AW'(b_cos_i);  axy[2] = AW'(b_sin_i);
    axx[3] = -AW'(b_sin_i); axy[3] = AW'(b_cos_i);
  end

  // Stage 1: exact axis-to-axis dots, hold the inputs.
  logic signed [DW-1:0]         dot_q [NumAxes][NumAxes];
  logic signed [AW-1:0]         s1_lx_q [NumAxes];
  logic signed [AW-1:0]         s1_ly_q [NumAxes];
  logic signed [COORD_BITS-1:0] s1_cax_q, s1_cay_q, s1_cbx_q, s1_cby_q;
  logic        [HalfBits-1:0]   s1_h_q [NumAxes];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < NumAxes; i++) begin
        for (int j = 0; j < NumAxes; j++) begin
          dot_q[i][j] <= DW'(axx[i]) * DW'(axx[j]) + DW'(axy[i]) * DW'(axy[j]);
        end
        s1_lx_q[i] <= axx[i];
        s1_ly_q[i] <= axy[i];
      end
      s1_cax_q <= a_center_x_i; s1_cay_q <= a_center_y_i;
      s1_cbx_q <= b_center_x_i; s1_cby_q <= b_center_y_i;
      s1_h_q[0] <= a_half_width_i;  s1_h_q[1] <= a_half_height_i;
      s1_h_q[2] <= b_half_width_i;  s1_h_q[3] <= b_half_height_i;
    end
  end

  // Stage 2: radius products (one per box half extent and axis), center
  // projections and center differences.
  logic [PW-1:0]        rp_q [NumAxes][NumAxes];  // [axis L][box axis j]
  logic signed [CW-1:0] pa_q [NumAxes];
  logic signed [CW-1:0] pb_q [NumAxes];
  logic signed [AW-1:0] s2_lx_q [NumAxes];
  logic signed [AW-1:0] s2_ly_q [NumAxes];
  logic signed [COORD_BITS:0] s2_dx_q, s2_dy_q;

  logic [DW-1:0]  adot [NumAxes][NumAxes];
  logic [RDW-1:0] rdot [NumAxes][NumAxes];
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      for (int j = 0; j < NumAxes; j++) begin
        adot[i][j] = dot_q[i][j][DW-1] ? DW'(-dot_q[i][j]) : DW'(dot_q[i][j]);
        rdot[i][j] = RDW'((adot[i][j] + (DW'(1) << (AF - 1))) >> AF);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int l = 0; l < NumAxes; l++) begin
        for (int j = 0; j < NumAxes; j++) begin
          rp_q[l][j] <= PW'(s1_h_q[j]) * PW'(rdot[j][l]);
        end
        pa_q[l] <= CW'(s1_cax_q) * CW'(s1_lx_q[l]) + CW'(s1_cay_q) * CW'(s1_ly_q[l]);
        pb_q[l] <= CW'(s1_cbx_q) * CW'(s1_lx_q[l]) + CW'(s1_cby_q) * CW'(s1_ly_q[l]);
        s2_lx_q[l] <= s1_lx_q[l];
        s2_ly_q[l] <= s1_ly_q[l];
      end
      s2_dx_q <= (COORD_BITS+1)'(s1_cbx_q) - (COORD_BITS+1)'(s1_cax_q);
      s2_dy_q <= (COORD_BITS+1)'(s1_cby_q) - (COORD_BITS+1)'(s1_cay_q);
    end
  end

  // Stage 3: interval bounds per axis, direction dot per axis.
  logic signed [BW-1:0]  mina_q [NumAxes];
  logic signed [BW-1:0]  maxa_q [NumAxes];
  logic signed [BW-1:0]  minb_q [NumAxes];
  logic signed [BW-1:0]  maxb_q [NumAxes];
  logic signed [DDW-1:0] dd_q [NumAxes];
  logic signed [AW-1:0]  s3_lx_q [NumAxes];
  logic signed [AW-1:0]  s3_ly_q [NumAxes];
  logic signed [BW-1:0]  ra [NumAxes];
  logic signed [BW-1:0]  rb [NumAxes];
  always_comb begin
    for (int l = 0; l < NumAxes; l++) begin
      ra[l] = BW'(rp_q[l][0]) + BW'(rp_q[l][1]);
      rb[l] = BW'(rp_q[l][2]) + BW'(rp_q[l][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int l = 0; l < NumAxes; l++) begin
        mina_q[l] <= BW'(pa_q[l]) - ra[l];
        maxa_q[l] <= BW'(pa_q[l]) + ra[l];
        minb_q[l] <= BW'(pb_q[l]) - rb[l];
        maxb_q[l] <= BW'(pb_q[l]) + rb[l];
        dd_q[l]   <= DDW'(s2_dx_q) * DDW'(s2_lx_q[l]) + DDW'(s2_dy_q) * DDW'(s2_ly_q[l]);
        s3_lx_q[l] <= s2_lx_q[l];
        s3_ly_q[l] <= s2_ly_q[l];
      end
    end
  end

  // Stage 4: gap flag and overlap per axis.
  logic [NumAxes-1:0]   gap_q;
  logic signed [BW-1:0] ov_q [NumAxes];
  logic [NumAxes-1:0]   dpos_q;
  logic signed [AW-1:0] s4_lx_q [NumAxes];
  logic signed [AW-1:0] s4_ly_q [NumAxes];
  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int l = 0; l < NumAxes; l++) begin
        gap_q[l] <= (maxa_q[l] < minb_q[l]) || (maxb_q[l] < mina_q[l]);
        ov_q[l]  <= ((maxa_q[l] < maxb_q[l]) ? maxa_q[l] : maxb_q[l])
                  - ((mina_q[l] > minb_q[l]) ? mina_q[l] : minb_q[l]);
        dpos_q[l] <= dd_q[l] > 0;
        s4_lx_q[l] <= s3_lx_q[l];
        s4_ly_q[l] <= s3_ly_q[l];
      end
    end
  end

  // Stage 5: pick the first smallest overlap, orient, round and saturate.
  logic [1:0]           bi;
  logic signed [BW-1:0] best;
  logic signed [AW-1:0] nx, ny;
  logic [BW-1:0]        pen_full;
  logic                 hit;
  always_comb begin
    best = ov_q[0];
    bi   = 2'd0;
    for (int l = 1; l < NumAxes; l++) begin
      if (ov_q[l] < best) begin
        best = ov_q[l];
        bi   = 2'(l);
      end
    end
    nx = s4_lx_q[bi];
    ny = s4_ly_q[bi];
    if (dpos_q[bi]) begin
      nx = -nx;
      ny = -ny;
    end
    pen_full = (BW'(best) + (BW'(1) << (AF - 1))) >> AF;
    hit = !(|gap_q);
  end

  function automatic logic signed [NW-1:0] sat_n(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'((1 << (ANGLE_BITS - 1)) - 1);
    lo = -hi - AW'(1);
    if (v > hi) return NW'(hi);
    else if (v < lo) return NW'(lo);
    else return NW'(v);
  endfunction

  logic               hit_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic [PenBits-1:0] pen_q;
  always_ff @(posedge clk_i) begin
    if (en5) begin
      hit_q <= hit;
      nx_q  <= hit ? sat_n(nx) : '0;
      ny_q  <= hit ? sat_n(ny) : '0;
      pen_q <= !hit ? '0
             : (pen_full > BW'({PenBits{1'b1}})) ? {PenBits{1'b1}}
             : PenBits'(pen_full);
    end
  end

  assign out_valid_o   = v5_q;
  assign hit_o         = hit_q;
  assign normal_x_o    = nx_q;
  assign normal_y_o    = ny_q;
  assign penetration_o = pen_q;

  // A stalled result stays valid and holds its hit flag and depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(penetration_o)
      && $stable(hit_o))
    else $error("stalled result changed");
  // A miss carries zero normal and depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> normal_x_o == 0 && normal_y_o == 0 && penetration_o == 0)
    else $error("miss with nonzero payload");
  // Input stall only when the whole pipe is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && v3_q && v4_q && v5_q && out_stall_i)
    else $error("input stalled with room in pipe");
endmodule
